>>> sv/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared widths, codes and types of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    // Field widths
    localparam int STATUS_BITS = 8;
    localparam int BYTE_BITS   = 8;
    localparam int COORD_BITS  = 12;
    localparam int PLEN_BITS   = 3;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int ENTRY_W     = STATUS_BITS + 2 * COORD_BITS;

    typedef logic [COORD_BITS-1:0]  coord_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LENGTH = 2'd2;

    // Configuration reset values
    localparam coord_t                 WIDTH_RESET  = 12'd1024;
    localparam coord_t                 HEIGHT_RESET = 12'd768;
    localparam logic [PLEN_BITS-1:0]   PLEN_RESET   = 3'd3;
    localparam logic [PLEN_BITS-1:0]   PLEN_WHEEL   = 3'd4;

    // Cursor start position: screen center
    localparam coord_t POS_X_RESET = 12'd512;
    localparam coord_t POS_Y_RESET = 12'd384;

    // Item action codes
    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // Sign bits inside the status byte
    localparam int STATUS_X_SIGN = 4;
    localparam int STATUS_Y_SIGN = 5;

    // Packet completion toward the event queue
    typedef struct packed {
        logic    valid;
        status_t status;
    } push_t;

endpackage

>>> sv/ps2mct_cmd_if.sv
// ----------------------------------------------------------------------------
// ps2mct_cmd_if
// Command channel: a mouse byte or a queue read request.
// ----------------------------------------------------------------------------
interface ps2mct_cmd_if
    import ps2mct_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 burst_end;

    modport source (output valid, output action, output data_byte, output burst_end,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input burst_end,
                    output ready);
endinterface

>>> sv/ps2mct_evt_if.sv
// ----------------------------------------------------------------------------
// ps2mct_evt_if
// Event channel: one popped queue entry, or an empty-queue answer.
// ----------------------------------------------------------------------------
interface ps2mct_evt_if
    import ps2mct_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    event_valid;
    status_t button_status;
    coord_t  cursor_x;
    coord_t  cursor_y;

    modport source (output valid, output event_valid, output button_status,
                    output cursor_x, output cursor_y, input ready);
    modport sink   (input valid, input event_valid, input button_status,
                    input cursor_x, input cursor_y, output ready);
endinterface

>>> sv/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// PS/2 mouse packet decoder with clamped cursor and a ring event queue.
// ----------------------------------------------------------------------------
// The block takes one command item per clock while cmd.ready is high. A
// byte item (action 0) feeds the packet assembler and gives no result; the
// packet's last byte moves the cursor and pushes {status, x, y} into the
// event queue in that same cycle. A read item (action 1) pops one entry, or
// answers empty if the queue is empty; its result passes through the
// registered queue memory read and then the output register. These two
// registers together hold two results, so cmd.ready stays high at full rate
// as long as evt.ready does, and drops only when both are occupied. The
// queue has no full check: a push into the last free entry brings the head
// onto the tail and the queue then reads as empty. No clearing pass is run
// after reset; the queue is usable from the first cycle out of reset.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    ps2mct_cmd_if.sink           cmd,
    ps2mct_evt_if.source         evt,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int                PTR_W    = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    // Configuration
    coord_t               screen_width_reg;
    coord_t               screen_height_reg;
    logic [PLEN_BITS-1:0] packet_length_reg;

    // Event queue
    logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [ENTRY_W-1:0] rd_data_reg;

    // Result path
    logic    rd_valid_reg, rd_valid_next;
    logic    rd_hit_reg;
    logic    out_valid_reg, out_valid_next;
    logic    out_event_reg;
    status_t out_status_reg;
    coord_t  out_x_reg;
    coord_t  out_y_reg;

    logic   out_free;
    logic   stage_free;
    logic   cmd_fire;
    logic   byte_fire;
    logic   read_fire;
    logic   queue_hit;
    logic   out_load;
    push_t  push;
    coord_t push_x;
    coord_t push_y;

    // Handshake
    assign out_free   = !out_valid_reg || evt.ready;
    assign stage_free = !rd_valid_reg || out_free;
    assign cmd.ready  = stage_free;
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign byte_fire  = cmd_fire && (cmd.action == ACTION_BYTE);
    assign read_fire  = cmd_fire && (cmd.action == ACTION_READ);
    assign queue_hit  = (head_reg != tail_reg);
    assign out_load   = out_free && rd_valid_reg;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
            packet_length_reg <= PLEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[COORD_BITS-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[COORD_BITS-1:0];
                CFG_PACKET_LENGTH: packet_length_reg <= cfg_data[PLEN_BITS-1:0];
                default: ;
            endcase
        end
    end

    ps2mct_packet u_packet (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_fire),
        .data_byte     (cmd.data_byte),
        .burst_end     (cmd.burst_end),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .wheel_mode    (packet_length_reg == PLEN_WHEEL),
        .push          (push),
        .pos_x         (push_x),
        .pos_y         (push_y)
    );

    // Advance the ring pointers
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (push.valid)
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        if (read_fire && queue_hit)
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    end

    // Queue memory: write at head, registered read at tail
    always_ff @(posedge clk)
    begin
        if (push.valid)
            queue_mem[head_reg] <= {push.status, push_x, push_y};
        if (read_fire && queue_hit)
            rd_data_reg <= queue_mem[tail_reg];
    end

    // Result path control
    always_comb
    begin
        if (read_fire)
            rd_valid_next = 1'b1;
        else if (out_free)
            rd_valid_next = 1'b0;
        else
            rd_valid_next = rd_valid_reg;
        out_valid_next = out_free ? rd_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the hit flag with the read data; zero the fields of an empty read
    always_ff @(posedge clk)
    begin
        if (read_fire)
            rd_hit_reg <= queue_hit;
        if (out_load)
        begin
            out_event_reg <= rd_hit_reg;
            if (rd_hit_reg)
            begin
                out_status_reg <= rd_data_reg[ENTRY_W-1 -: STATUS_BITS];
                out_x_reg      <= rd_data_reg[2*COORD_BITS-1 -: COORD_BITS];
                out_y_reg      <= rd_data_reg[COORD_BITS-1:0];
            end
            else
            begin
                out_status_reg <= '0;
                out_x_reg      <= '0;
                out_y_reg      <= '0;
            end
        end
    end

    assign evt.valid         = out_valid_reg;
    assign evt.event_valid   = out_event_reg;
    assign evt.button_status = out_status_reg;
    assign evt.cursor_x      = out_x_reg;
    assign evt.cursor_y      = out_y_reg;

endmodule

>>> sv/ps2mct_packet.sv
// ----------------------------------------------------------------------------
// ps2mct_packet
// Packet assembler and cursor integrator: gathers 3 or 4 mouse bytes,
// applies the sign-extended deltas to the clamped cursor position.
// ----------------------------------------------------------------------------
module ps2mct_packet
    import ps2mct_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    input  logic [BYTE_BITS-1:0] data_byte,
    input  logic                 burst_end,
    input  coord_t               screen_width,
    input  coord_t               screen_height,
    input  logic                 wheel_mode,
    output push_t                push,
    output coord_t               pos_x,
    output coord_t               pos_y
);

    localparam int SUM_W = COORD_BITS + 2;

    logic [PLEN_BITS-1:0] byte_count_reg, byte_count_next;
    status_t              packet_status_reg, packet_status_next;
    logic [BYTE_BITS-1:0] packet_dx_reg, packet_dx_next;
    logic [BYTE_BITS-1:0] packet_dy_reg, packet_dy_next;
    coord_t               position_x_reg, position_x_next;
    coord_t               position_y_reg, position_y_next;

    logic [PLEN_BITS-1:0] count_inc;
    logic [PLEN_BITS-1:0] need;
    logic                 done;
    logic [BYTE_BITS-1:0] dy_byte;
    logic                 moving;
    logic signed [9:0]    delta_x;
    logic signed [9:0]    delta_y;
    coord_t               step_x;
    coord_t               step_y;

    // Add a signed delta and clamp to 0..limit
    function automatic coord_t clamp_axis(coord_t pos, logic signed [9:0] delta,
                                          coord_t limit);
        logic signed [SUM_W-1:0] sum;
        sum = $signed({2'b00, pos}) + SUM_W'(delta);
        if (sum < 0)
            return '0;
        else if (sum > $signed({2'b00, limit}))
            return limit;
        else
            return sum[COORD_BITS-1:0];
    endfunction

    // Packet framing
    assign count_inc = byte_count_reg + 3'd1;
    assign need      = wheel_mode ? PLEN_WHEEL : 3'd3;
    assign done      = (count_inc >= need);

    // The Y byte is the current byte when a 3-byte packet ends on it
    assign dy_byte = (byte_count_reg == 3'd2) ? data_byte : packet_dy_reg;
    assign moving  = (packet_dx_reg != '0) || (dy_byte != '0);

    // Sign-extend with the status sign bits; negate Y for screen space
    assign delta_x = $signed({packet_status_reg[STATUS_X_SIGN],
                              packet_status_reg[STATUS_X_SIGN], packet_dx_reg});
    assign delta_y = -$signed({packet_status_reg[STATUS_Y_SIGN],
                               packet_status_reg[STATUS_Y_SIGN], dy_byte});

    assign step_x = clamp_axis(position_x_reg, delta_x, screen_width);
    assign step_y = clamp_axis(position_y_reg, delta_y, screen_height);

    // Position reported with the completed packet
    assign pos_x = moving ? step_x : position_x_reg;
    assign pos_y = moving ? step_y : position_y_reg;

    assign push.valid  = byte_valid && done;
    assign push.status = packet_status_reg;

    // Capture bytes and advance the byte counter
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        packet_status_next = packet_status_reg;
        packet_dx_next     = packet_dx_reg;
        packet_dy_next     = packet_dy_reg;
        position_x_next    = position_x_reg;
        position_y_next    = position_y_reg;
        if (byte_valid)
        begin
            case (byte_count_reg)
                3'd0:    packet_status_next = data_byte;
                3'd1:    packet_dx_next     = data_byte;
                3'd2:    packet_dy_next     = data_byte;
                default: ;
            endcase
            if (done)
            begin
                byte_count_next = '0;
                position_x_next = pos_x;
                position_y_next = pos_y;
            end
            else if (burst_end)
            begin
                // drop the partial packet
                byte_count_next = '0;
            end
            else
            begin
                byte_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            packet_status_reg <= '0;
            packet_dx_reg     <= '0;
            packet_dy_reg     <= '0;
            position_x_reg    <= POS_X_RESET;
            position_y_reg    <= POS_Y_RESET;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            packet_status_reg <= packet_status_next;
            packet_dx_reg     <= packet_dx_next;
            packet_dy_reg     <= packet_dy_next;
            position_x_reg    <= position_x_next;
            position_y_reg    <= position_y_next;
        end
    end

endmodule

>>> sv/ps2mct_checker.sv
// ----------------------------------------------------------------------------
// ps2mct_checker
// Port-level checks of the cursor tracker, bound to the top level.
// ----------------------------------------------------------------------------
module ps2mct_checker
    import ps2mct_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    cmd_valid,
    input logic    cmd_ready,
    input logic    cmd_action,
    input logic    evt_valid,
    input logic    evt_ready,
    input logic    evt_event_valid,
    input status_t evt_button_status,
    input coord_t  evt_cursor_x,
    input coord_t  evt_cursor_y
);

    logic [1:0] pending_reg, pending_next;
    logic       read_in;
    logic       evt_out;

    assign read_in = cmd_valid && cmd_ready && (cmd_action == ACTION_READ);
    assign evt_out = evt_valid && evt_ready;

    // Count read items whose result has not left yet
    always_comb
    begin
        pending_next = pending_reg;
        if (read_in && !evt_out)
            pending_next = pending_reg + 2'd1;
        else if (!read_in && evt_out)
            pending_next = pending_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // An empty-queue answer carries zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_event_valid |->
            evt_button_status == '0 && evt_cursor_x == '0 && evt_cursor_y == '0)
        else $error("empty read with nonzero fields");

    // Every result answers an earlier read item; byte items make none
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> pending_reg != 2'd0)
        else $error("result without a pending read");

    // At most two results are held inside the block
    a_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more than two reads outstanding");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_valid)
            && $stable(evt_button_status) && $stable(evt_cursor_x)
            && $stable(evt_cursor_y))
        else $error("stalled result changed");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .cmd_action        (cmd.action),
    .evt_valid         (evt.valid),
    .evt_ready         (evt.ready),
    .evt_event_valid   (evt.event_valid),
    .evt_button_status (evt.button_status),
    .evt_cursor_x      (evt.cursor_x),
    .evt_cursor_y      (evt.cursor_y)
);

>>> tb/sv/ps2_mouse_cursor_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker_test
// Self-checking bench for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
// A clocked driver sends mouse bytes and queue reads from a backlog that the
// stimulus block fills phase by phase. An in-bench cursor tracker follows
// every accepted item and queues the event each read should return. A
// clocked monitor stalls the event channel on its own pattern and checks
// every event field against that queue. Registers change only between
// phases, after all events are in.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker_test;
    import ps2mct_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int COORD_TOP   = (1 << COORD_BITS) - 1;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic                 pause;
        logic                 action;
        logic [BYTE_BITS-1:0] data_byte;
        logic                 burst_end;
    } cmd_item_t;

    typedef struct packed {
        logic    event_valid;
        status_t button_status;
        coord_t  cursor_x;
        coord_t  cursor_y;
    } cursor_event_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TWO_OF_THREE, RX_TRICKLE} rx_mode_e;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ps2mct_cmd_if cmd_ch ();
    ps2mct_evt_if evt_ch ();

    ps2_mouse_cursor_tracker #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .evt       (evt_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus backlog and expected events
    cmd_item_t     cmd_backlog[$];
    cursor_event_t expected_events[$];
    int            queued_count   = 0;
    int            accepted_count = 0;
    int            mismatch_count = 0;

    // Tracker copy of registers and state
    coord_t                 lim_x;
    coord_t                 lim_y;
    logic [PLEN_BITS-1:0]   plen_cfg;
    int                     asm_count;
    status_t                asm_status;
    logic [BYTE_BITS-1:0]   asm_dx;
    logic [BYTE_BITS-1:0]   asm_dy;
    coord_t                 cursor_px;
    coord_t                 cursor_py;
    status_t                evq_status[QUEUE_DEPTH];
    coord_t                 evq_x[QUEUE_DEPTH];
    coord_t                 evq_y[QUEUE_DEPTH];
    int                     evq_head;
    int                     evq_tail;

    // Driver and monitor pacing
    cmd_item_t   cur_item;
    int          burst_left = 0;
    int          gap_left   = 0;
    rx_mode_e    rx_mode    = RX_OPEN;
    int unsigned rx_tick    = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Clamp one axis to 0..limit, limit capped to the coordinate range
    function automatic coord_t clamp_axis_pos(coord_t pos, int delta, coord_t limit);
        int upper;
        int v;
        upper = int'(limit);
        if (upper > COORD_TOP)
            upper = COORD_TOP;
        v = int'(pos) + delta;
        if (v > upper)
            v = upper;
        if (v < 0)
            v = 0;
        return coord_t'(v);
    endfunction

    // Follow one accepted item; a read queues the event it must return
    task automatic track_item(input cmd_item_t it);
        int            need;
        int            dx;
        int            dy;
        cursor_event_t ev;
        if (it.action == ACTION_BYTE)
        begin
            need = (plen_cfg == PLEN_WHEEL) ? 4 : 3;
            case (asm_count)
                0: asm_status = it.data_byte;
                1: asm_dx     = it.data_byte;
                2: asm_dy     = it.data_byte;
                default: ;
            endcase
            asm_count++;
            if (asm_count >= need)
            begin
                asm_count = 0;
                // Zero raw deltas leave the cursor alone
                if (asm_dx != 0 || asm_dy != 0)
                begin
                    dx = int'(asm_dx);
                    dy = int'(asm_dy);
                    if (asm_status[STATUS_X_SIGN])
                        dx -= (1 << BYTE_BITS);
                    if (asm_status[STATUS_Y_SIGN])
                        dy -= (1 << BYTE_BITS);
                    cursor_px = clamp_axis_pos(cursor_px, dx, lim_x);
                    cursor_py = clamp_axis_pos(cursor_py, -dy, lim_y);
                end
                evq_status[evq_head] = asm_status;
                evq_x[evq_head]      = cursor_px;
                evq_y[evq_head]      = cursor_py;
                evq_head = (evq_head + 1) % QUEUE_DEPTH;
            end
            else if (it.burst_end)
                asm_count = 0;
        end
        else
        begin
            if (evq_head == evq_tail)
                ev = '0;
            else
            begin
                ev.event_valid   = 1'b1;
                ev.button_status = evq_status[evq_tail];
                ev.cursor_x      = evq_x[evq_tail];
                ev.cursor_y      = evq_y[evq_tail];
                evq_tail = (evq_tail + 1) % QUEUE_DEPTH;
            end
            expected_events.push_back(ev);
        end
    endtask

    // Driver: bursts of items with random gaps, holding at pause points
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid     <= 1'b0;
            cmd_ch.action    <= ACTION_BYTE;
            cmd_ch.data_byte <= '0;
            cmd_ch.burst_end <= 1'b0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                track_item(cur_item);
                accepted_count++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (cmd_backlog.size() > 0 && cmd_backlog[0].pause)
                begin
                    if (expected_events.size() == 0)
                        void'(cmd_backlog.pop_front());
                    cmd_ch.valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cur_item = cmd_backlog.pop_front();
                    cmd_ch.action    <= cur_item.action;
                    cmd_ch.data_byte <= cur_item.data_byte;
                    cmd_ch.burst_end <= cur_item.burst_end;
                    cmd_ch.valid     <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // Report one field that differs from the expected value
    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // Monitor: check each event, stall ready on a changing pattern
    always @(posedge clk)
    begin
        cursor_event_t want;
        if (!rst_n)
            evt_ch.ready <= 1'b0;
        else
        begin
            if (evt_ch.valid && evt_ch.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected event expected none actual %0h/%0h/%0h/%0h",
                             $time, evt_ch.event_valid, evt_ch.button_status,
                             evt_ch.cursor_x, evt_ch.cursor_y);
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_valid", want.event_valid, evt_ch.event_valid);
                    check_field("button_status", want.button_status, evt_ch.button_status);
                    check_field("cursor_x", want.cursor_x, evt_ch.cursor_x);
                    check_field("cursor_y", want.cursor_y, evt_ch.cursor_y);
                end
            end
            rx_tick++;
            if (rx_tick % 256 == 0)
                rx_mode = rx_mode_e'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:         evt_ch.ready <= 1'b1;
                RX_COIN:         evt_ch.ready <= 1'($urandom_range(0, 1));
                RX_TWO_OF_THREE: evt_ch.ready <= (rx_tick % 3) != 0;
                default:         evt_ch.ready <= (rx_tick % 9) == 8;
            endcase
        end
    end

    task automatic add_item(input logic action, input logic [BYTE_BITS-1:0] data,
                            input logic burst_end);
        cmd_item_t it;
        it.pause     = 1'b0;
        it.action    = action;
        it.data_byte = data;
        it.burst_end = burst_end;
        cmd_backlog.push_back(it);
        queued_count++;
    endtask

    // Hold the sender until every expected event has arrived
    task automatic add_pause();
        cmd_item_t it;
        it       = '0;
        it.pause = 1'b1;
        cmd_backlog.push_back(it);
    endtask

    // Pick a 9-bit signed delta, biased toward the drift direction
    function automatic logic [8:0] pick_delta(int drift);
        logic [8:0] d;
        d = 9'($urandom_range(0, 511));
        if (drift > 0 && $urandom_range(0, 1) == 1)
            d = {1'b0, 8'($urandom_range(128, 255))};
        else if (drift < 0 && $urandom_range(0, 1) == 1)
            d = {1'b1, 8'($urandom_range(0, 127))};
        return d;
    endfunction

    // Well-formed packet with random content
    task automatic add_random_packet(input int need, input int drift_x, input int drift_y);
        logic [8:0] mx;
        logic [8:0] my;
        status_t    st;
        logic       tail_be;
        mx = pick_delta(drift_x);
        // screen y moves opposite to the mouse y delta
        my = pick_delta(-drift_y);
        if ($urandom_range(0, 9) == 0)
        begin
            mx[7:0] = '0;
            my[7:0] = '0;
        end
        st = status_t'($urandom_range(0, 255));
        st[STATUS_X_SIGN] = mx[8];
        st[STATUS_Y_SIGN] = my[8];
        tail_be = ($urandom_range(0, 3) != 0);
        add_item(ACTION_BYTE, st, 1'b0);
        add_item(ACTION_BYTE, mx[7:0], 1'b0);
        add_item(ACTION_BYTE, my[7:0], (need == 3) ? tail_be : 1'b0);
        if (need == 4)
            add_item(ACTION_BYTE, 8'($urandom_range(0, 255)), tail_be);
    endtask

    task automatic add_read();
        add_item(ACTION_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  lim_x    = coord_t'(val);
            CFG_SCREEN_HEIGHT: lim_y    = coord_t'(val);
            CFG_PACKET_LENGTH: plen_cfg = val[PLEN_BITS-1:0];
            default: ;
        endcase
    endtask

    // Wait until every item is accepted and every event is in, then settle
    task automatic drain();
        while (cmd_backlog.size() != 0 || accepted_count != queued_count ||
               expected_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        static int phase_w[NUM_PHASES]    = '{1, 4095, 4095, 1, 640, 0, 1024};
        static int phase_h[NUM_PHASES]    = '{1, 4095, 1, 4095, 480, 0, 768};
        static int phase_plen[NUM_PHASES] = '{4, 3, 7, 0, 4, -1, 3};
        int w;
        int h;
        int pl;
        int need;
        int drift_x;
        int drift_y;
        int start;
        int pick;
        int occ;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;

        lim_x      = WIDTH_RESET;
        lim_y      = HEIGHT_RESET;
        plen_cfg   = PLEN_RESET;
        asm_count  = 0;
        asm_status = '0;
        asm_dx     = '0;
        asm_dy     = '0;
        cursor_px  = POS_X_RESET;
        cursor_py  = POS_Y_RESET;
        evq_head   = 0;
        evq_tail   = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            evq_status[i] = '0;
            evq_x[i]      = '0;
            evq_y[i]      = '0;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty read, then packets back to back within one burst
        add_item(ACTION_READ, 8'h00, 1'b0);
        add_item(ACTION_BYTE, 8'h08, 1'b0);
        add_item(ACTION_BYTE, 8'h7f, 1'b0);
        add_item(ACTION_BYTE, 8'h00, 1'b0);
        // zero raw deltas with both sign bits set
        add_item(ACTION_BYTE, 8'h30, 1'b0);
        add_item(ACTION_BYTE, 8'h00, 1'b0);
        add_item(ACTION_BYTE, 8'h00, 1'b1);
        // deltas of -128 on both axes, every status bit set
        add_item(ACTION_BYTE, 8'hff, 1'b0);
        add_item(ACTION_BYTE, 8'h80, 1'b0);
        add_item(ACTION_BYTE, 8'h80, 1'b1);
        // bursts that end before the packet is complete
        add_item(ACTION_BYTE, 8'h18, 1'b1);
        add_item(ACTION_BYTE, 8'h08, 1'b0);
        add_item(ACTION_BYTE, 8'h01, 1'b1);
        // largest positive x, large negative y
        add_item(ACTION_BYTE, 8'h20, 1'b0);
        add_item(ACTION_BYTE, 8'hff, 1'b0);
        add_item(ACTION_BYTE, 8'h01, 1'b1);
        // reads ignore the byte fields; the last one finds the queue empty
        repeat (4) add_item(ACTION_READ, 8'hff, 1'b1);
        add_item(ACTION_READ, 8'h55, 1'b0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            w  = (phase_w[p] == 0) ? $urandom_range(1, 4095) : phase_w[p];
            h  = (phase_h[p] == 0) ? $urandom_range(1, 4095) : phase_h[p];
            pl = (phase_plen[p] < 0) ? $urandom_range(0, 7) : phase_plen[p];
            write_reg(CFG_SCREEN_WIDTH, CFG_W'(w));
            write_reg(CFG_SCREEN_HEIGHT, CFG_W'(h));
            write_reg(CFG_PACKET_LENGTH, CFG_W'(pl));
            need    = (pl == int'(PLEN_WHEEL)) ? 4 : 3;
            drift_x = $urandom_range(0, 2) - 1;
            drift_y = $urandom_range(0, 2) - 1;

            // Overflow: empty the queue, then wrap it with pushes only
            if (p == 3)
            begin
                occ = (evq_head - evq_tail + QUEUE_DEPTH) % QUEUE_DEPTH;
                repeat (occ) add_read();
                repeat (QUEUE_DEPTH) add_random_packet(need, drift_x, drift_y);
                add_read();
                repeat (6) add_random_packet(need, drift_x, drift_y);
                repeat (8) add_read();
            end

            start = queued_count;
            while (queued_count - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    add_random_packet(need, drift_x, drift_y);
                else if (pick < 80)
                    add_read();
                else if (pick < 90)
                begin
                    // broken packet cut short by the end of the burst
                    repeat ($urandom_range(0, need - 2))
                        add_item(ACTION_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                    add_item(ACTION_BYTE, 8'($urandom_range(0, 255)), 1'b1);
                end
                else
                    add_item(ACTION_BYTE, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                if ((p == 1 && queued_count - start >= PHASE_ITEMS / 2 &&
                     queued_count - start < PHASE_ITEMS / 2 + 4) ||
                    $urandom_range(0, 99) == 0)
                    add_pause();
            end
            // close any partial packet before the registers change
            add_item(ACTION_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            drain();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
sv/ps2mct_pkg.sv
sv/ps2mct_cmd_if.sv
sv/ps2mct_evt_if.sv
sv/ps2mct_packet.sv
sv/ps2_mouse_cursor_tracker.sv
sv/ps2mct_checker.sv
tb/sv/ps2_mouse_cursor_tracker_test.sv
